/* hw/rtl/vn_pkg.sv */
// package: widths, register indexes and defaults for the vector normalizer
package vn_pkg;

    localparam int COMP_W        = 24;
    localparam int NUM_COMP      = 3;
    localparam int DATA_W        = COMP_W * NUM_COMP;
    localparam int THR_W         = 48;
    localparam int CFG_IDX_W     = 1;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [THR_W-1:0] THR_RESET = 48'd42950;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_MODE    = 1'd1;

    // degenerate answer codes
    localparam logic MODE_AXIS = 1'b0;
    localparam logic MODE_COPY = 1'b1;

endpackage

/* hw/rtl/vec3_normalize.sv */
// vec3_normalize: streaming normalizer for signed fixed-point 3D vectors
//
// Each transaction carries one vector (x, y, z), two's complement with FRAC_BITS fraction
// bits. The block forms the exact squared length S and compares it with length_threshold;
// above it, each component becomes sign(c) * floor(|c| * 2^FRAC_BITS / sqrt(S)). At or
// below it the vector is degenerate (m_tuser high) and fallback_mode picks the answer:
// the axis of the largest signed component set to one (lower index wins a tie), or the
// input copied. One vector is accepted every cycle unless the output stalls, which holds
// the whole pipeline: input register with squaring multipliers, sum and threshold stage,
// one shift-add-compare stage per quotient bit (FRAC_BITS + 1 of them), output register.
module vec3_normalize #(
    parameter int FRAC_BITS = vn_pkg::DEF_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vn_pkg::DATA_W-1:0]    s_tdata,    // in_x, in_y, in_z
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vn_pkg::DATA_W-1:0]    m_tdata,    // out_x, out_y, out_z
    output logic                         m_tuser,    // degenerate
    input  logic                         cfg_we,
    input  logic [vn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vn_pkg::THR_W-1:0]     cfg_wdata
);
    import vn_pkg::*;

    localparam int STEPS = FRAC_BITS + 1;
    localparam int SQ_W  = 2 * COMP_W - 1;
    localparam int SUM_W = 2 * COMP_W;
    localparam int N_W   = SQ_W + 2 * FRAC_BITS;
    localparam int P_W   = 2 * FRAC_BITS + 2 + SUM_W;
    localparam int QS_W  = FRAC_BITS + 1 + SUM_W;
    localparam int Q_W   = FRAC_BITS + 1;

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic             mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            mode_reg <= MODE_AXIS;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LENGTH_THRESHOLD: thr_reg  <= cfg_wdata;
                REG_FALLBACK_MODE:    mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // global advance: pipeline moves when the output slot is free or taken
    logic ce;
    logic m_valid_reg;
    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    // input stage: magnitudes and squares
    logic signed [COMP_W-1:0] in_c   [NUM_COMP];
    logic        [COMP_W-1:0] in_mag [NUM_COMP];

    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            in_c[i]   = s_tdata[i*COMP_W +: COMP_W];
            in_mag[i] = in_c[i][COMP_W-1] ? COMP_W'(-in_c[i]) : in_c[i];
        end
    end

    logic                     v1_reg;
    logic signed [COMP_W-1:0] raw1_reg [NUM_COMP];
    logic        [SQ_W-1:0]   sq1_reg  [NUM_COMP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                raw1_reg[i] <= in_c[i];
                sq1_reg[i]  <= SQ_W'({{COMP_W{1'b0}}, in_mag[i]} *
                                     {{COMP_W{1'b0}}, in_mag[i]});
            end
        end
    end

    // sum stage: squared length, threshold test and degenerate answer
    logic [SUM_W-1:0]         sum_s;
    logic                     sum_deg;
    logic [COMP_W-1:0]        fb_c [NUM_COMP];
    logic [COMP_W-1:0]        one_c;

    assign one_c   = COMP_W'(1) << FRAC_BITS;
    assign sum_s   = SUM_W'(sq1_reg[0]) + SUM_W'(sq1_reg[1]) + SUM_W'(sq1_reg[2]);
    assign sum_deg = (sum_s <= thr_reg);

    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            fb_c[i] = '0;
        end
        if (mode_reg == MODE_COPY) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                fb_c[i] = raw1_reg[i];
            end
        end else if (raw1_reg[0] >= raw1_reg[1]) begin
            if (raw1_reg[0] >= raw1_reg[2]) begin
                fb_c[0] = one_c;
            end else begin
                fb_c[2] = one_c;
            end
        end else begin
            if (raw1_reg[1] >= raw1_reg[2]) begin
                fb_c[1] = one_c;
            end else begin
                fb_c[2] = one_c;
            end
        end
    end

    // quotient pipeline, entry k is the input of the stage for bit FRAC_BITS-k
    logic                 vi_reg  [0:STEPS];
    logic                 deg_reg [0:STEPS];
    logic [SUM_W-1:0]     s_reg   [0:STEPS];
    logic [COMP_W-1:0]    fb_reg  [0:STEPS][NUM_COMP];
    logic                 neg_reg [0:STEPS][NUM_COMP];
    logic [N_W-1:0]       n_reg   [0:STEPS][NUM_COMP];
    logic [P_W-1:0]       p_reg   [0:STEPS][NUM_COMP];
    logic [QS_W-1:0]      qs_reg  [0:STEPS][NUM_COMP];
    logic [Q_W-1:0]       q_reg   [0:STEPS][NUM_COMP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vi_reg[0] <= 1'b0;
        end else if (ce) begin
            vi_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            deg_reg[0] <= sum_deg;
            s_reg[0]   <= sum_s;
            for (int i = 0; i < NUM_COMP; i++) begin
                fb_reg[0][i]  <= fb_c[i];
                neg_reg[0][i] <= raw1_reg[i][COMP_W-1];
                n_reg[0][i]   <= N_W'(sq1_reg[i]) << (2 * FRAC_BITS);
                p_reg[0][i]   <= '0;
                qs_reg[0][i]  <= '0;
                q_reg[0][i]   <= '0;
            end
        end
    end

    // one quotient bit per stage: try t = q + 2^b using running q^2*S and q*S
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = FRAC_BITS - k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vi_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vi_reg[k+1] <= vi_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                deg_reg[k+1] <= deg_reg[k];
                s_reg[k+1]   <= s_reg[k];
            end
        end

        for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
            logic [P_W-1:0] cand;
            logic           take;

            assign cand = p_reg[k][i] + (P_W'(qs_reg[k][i]) << (B + 1))
                        + (P_W'(s_reg[k]) << (2 * B));
            assign take = (cand <= P_W'(n_reg[k][i]));

            always_ff @(posedge aclk) begin
                if (ce) begin
                    fb_reg[k+1][i]  <= fb_reg[k][i];
                    neg_reg[k+1][i] <= neg_reg[k][i];
                    n_reg[k+1][i]   <= n_reg[k][i];
                    if (take) begin
                        p_reg[k+1][i]  <= cand;
                        qs_reg[k+1][i] <= qs_reg[k][i] + (QS_W'(s_reg[k]) << B);
                        q_reg[k+1][i]  <= q_reg[k][i] | (Q_W'(1) << B);
                    end else begin
                        p_reg[k+1][i]  <= p_reg[k][i];
                        qs_reg[k+1][i] <= qs_reg[k][i];
                        q_reg[k+1][i]  <= q_reg[k][i];
                    end
                end
            end
        end
    end

    // output stage: apply signs or pick the degenerate answer
    logic [DATA_W-1:0] out_data;
    logic [COMP_W-1:0] q_ext [NUM_COMP];

    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            q_ext[i] = COMP_W'(q_reg[STEPS][i]);
            if (deg_reg[STEPS]) begin
                out_data[i*COMP_W +: COMP_W] = fb_reg[STEPS][i];
            end else if (neg_reg[STEPS][i]) begin
                out_data[i*COMP_W +: COMP_W] = COMP_W'(-q_ext[i]);
            end else begin
                out_data[i*COMP_W +: COMP_W] = q_ext[i];
            end
        end
    end

    logic [DATA_W-1:0] m_data_reg;
    logic              m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= vi_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= out_data;
            m_user_reg <= deg_reg[STEPS];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transaction not captured");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(v1_reg) && $stable(vi_reg[0]) && $stable(vi_reg[STEPS]))
        else $error("pipeline moved during stall");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            ($signed(m_tdata[COMP_W-1:0]) <= $signed(one_c)) &&
            ($signed(m_tdata[COMP_W-1:0]) >= -$signed(one_c)))
        else $error("normalized component out of range");

endmodule
